FILE: sv/bssl_pkg.sv
// shared constants, codes and controller/datapath interface types for the sorted-set lookup unit
package bssl_pkg;

  // fixed field widths
  localparam int KEY_W    = 64;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 13;

  // default table geometry
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int BKT_SEL_W_DEF   = 10;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic key_write;
    logic fill_step;
    logic commit;
    logic bkt_read;
    logic range_set;
    logic probe_read;
    logic probe_step;
    logic finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic reject;
    logic fill_more;
    logic search_more;
  } dp_stat_t;

endpackage

FILE: sv/bucketed_sorted_set_lookup_unit.sv
// top level: sorted key table with bucketed binary-search lookup
// query: bucket start read, search range set, then at most ceil(log2(bucket size + 1)) probes,
//   each probe a registered key read and compare
// append: key write, a fill step per bucket filled, then commit; rejected: no write; clear and unused: finish
// busy drops as done rises, so the next item can be taken in the done cycle
// rst clears the count, last filled bucket and previous key; tables need no clearing pass
module bucketed_sorted_set_lookup_unit #(
  parameter int TABLE_DEPTH = bssl_pkg::TABLE_DEPTH_DEF,
  parameter int BKT_SEL_W   = bssl_pkg::BKT_SEL_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bssl_pkg::FUNC_W-1:0]     func,
  input  logic [bssl_pkg::KEY_W-1:0]      key,
  output logic                            done,
  output logic                            found,
  output logic [bssl_pkg::STATUS_W-1:0]   status,
  output logic [bssl_pkg::ENTRY_W-1:0]    entry_count
);

  bssl_pkg::dp_cmd_t  cmd;
  bssl_pkg::dp_stat_t stat;

  // controller
  bssl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath
  bssl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .BKT_SEL_W   (BKT_SEL_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .key         (key),
    .cmd         (cmd),
    .stat        (stat),
    .found       (found),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

FILE: sv/bssl_ctrl.sv
// sequencing state machine for append, query and clear items
module bssl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bssl_pkg::FUNC_W-1:0]   func,
  input  bssl_pkg::dp_stat_t            stat,
  output bssl_pkg::dp_cmd_t             cmd,
  output logic                          busy,
  output logic                          done
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_BKT    = 3'd3;
  localparam logic [2:0] S_RANGE  = 3'd4;
  localparam logic [2:0] S_SEARCH = 3'd5;
  localparam logic [2:0] S_PROBE  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (func)
            bssl_pkg::FUNC_APPEND: state_next = S_APPEND;
            bssl_pkg::FUNC_QUERY:  state_next = S_BKT;
            default:               state_next = S_FINISH;
          endcase
        end
      end
      S_APPEND: begin
        if (stat.reject) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.key_write = 1'b1;
          state_next    = S_FILL;
        end
      end
      S_FILL: begin
        if (stat.fill_more) begin
          cmd.fill_step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BKT: begin
        cmd.bkt_read = 1'b1;
        state_next   = S_RANGE;
      end
      S_RANGE: begin
        cmd.range_set = 1'b1;
        state_next    = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.search_more) begin
          cmd.probe_read = 1'b1;
          state_next     = S_PROBE;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
        state_next     = S_SEARCH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: sv/bssl_dp.sv
// key table, bucket start table, search registers and result registers
module bssl_dp #(
  parameter int TABLE_DEPTH = bssl_pkg::TABLE_DEPTH_DEF,
  parameter int BKT_SEL_W   = bssl_pkg::BKT_SEL_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bssl_pkg::FUNC_W-1:0]     func,
  input  logic [bssl_pkg::KEY_W-1:0]      key,
  input  bssl_pkg::dp_cmd_t               cmd,
  output bssl_pkg::dp_stat_t              stat,
  output logic                            found,
  output logic [bssl_pkg::STATUS_W-1:0]   status,
  output logic [bssl_pkg::ENTRY_W-1:0]    entry_count
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int NB    = 1 << BKT_SEL_W;

  // storage
  logic [bssl_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [CNT_W-1:0]           bkt_mem [NB];

  // item registers
  logic [bssl_pkg::FUNC_W-1:0]   func_q;
  logic [bssl_pkg::KEY_W-1:0]    key_q;

  // table state
  logic [CNT_W-1:0]              count;
  logic [BKT_SEL_W-1:0]          lf;
  logic [bssl_pkg::KEY_W-1:0]    prev_key;

  // search registers
  logic [CNT_W-1:0]              lo;
  logic [CNT_W-1:0]              hi;
  logic [CNT_W-1:0]              mid;
  logic                          hit;
  logic [bssl_pkg::KEY_W-1:0]    key_rd;
  logic [CNT_W-1:0]              bkt_rd0;
  logic [CNT_W-1:0]              bkt_rd1;

  // results
  logic                          found_q;
  logic [bssl_pkg::STATUS_W-1:0] status_q;

  logic [BKT_SEL_W-1:0]          bucket;
  logic [BKT_SEL_W-1:0]          bucket_inc;
  logic [BKT_SEL_W-1:0]          lf_inc;
  logic                          full;
  logic                          order;
  logic [CNT_W-1:0]              mid_next;
  logic [CNT_W-1:0]              lo_start;
  logic [CNT_W-1:0]              hi_raw;
  logic [CNT_W-1:0]              hi_start;
  logic [bssl_pkg::STATUS_W-1:0] status_next;

  // bucket of the held key and append checks
  assign bucket     = key_q[bssl_pkg::KEY_W-1 -: BKT_SEL_W];
  assign bucket_inc = bucket + BKT_SEL_W'(1);
  assign lf_inc     = lf + BKT_SEL_W'(1);
  assign full       = (count >= CNT_W'(TABLE_DEPTH));
  assign order      = (key_q < prev_key);

  assign stat.reject      = full | order;
  assign stat.fill_more   = (lf < bucket);
  assign stat.search_more = (lo < hi);

  // probe point of the binary search
  assign mid_next = lo + ((hi - lo) >> 1);

  // search range from the bucket start table; unfilled buckets start at the count
  always_comb begin
    if (bucket == '0) begin
      lo_start = '0;
    end else if (bucket <= lf) begin
      lo_start = bkt_rd0;
    end else begin
      lo_start = count;
    end
    if (bucket < lf) begin
      hi_raw = bkt_rd1;
    end else begin
      hi_raw = count;
    end
    hi_start = (hi_raw > count) ? count : hi_raw;
  end

  // result status for the item in hand
  always_comb begin
    status_next = bssl_pkg::STATUS_OK;
    if (func_q == bssl_pkg::FUNC_APPEND) begin
      if (full) begin
        status_next = bssl_pkg::STATUS_FULL;
      end else if (order) begin
        status_next = bssl_pkg::STATUS_ORDER;
      end
    end
  end

  // key table: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.key_write) begin
      key_mem[count[AW-1:0]] <= key_q;
    end
    if (cmd.probe_read) begin
      key_rd <= key_mem[mid_next[AW-1:0]];
    end
  end

  // bucket start table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      bkt_mem[lf_inc] <= count;
    end
    if (cmd.bkt_read) begin
      bkt_rd0 <= bkt_mem[bucket];
      bkt_rd1 <= bkt_mem[bucket_inc];
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      lf       <= '0;
      prev_key <= '0;
    end else begin
      if (cmd.fill_step) begin
        lf <= lf_inc;
      end
      if (cmd.commit) begin
        count    <= count + CNT_W'(1);
        prev_key <= key_q;
      end
      if (cmd.finish && func_q == bssl_pkg::FUNC_CLEAR) begin
        count    <= '0;
        lf       <= '0;
        prev_key <= '0;
      end
    end
  end

  // item capture, search steps and result capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      key_q  <= key;
    end
    if (cmd.range_set) begin
      lo  <= lo_start;
      hi  <= hi_start;
      hit <= 1'b0;
    end
    if (cmd.probe_read) begin
      mid <= mid_next;
    end
    if (cmd.probe_step) begin
      if (key_rd < key_q) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
      if (key_rd == key_q) begin
        hit <= 1'b1;
      end
    end
    if (cmd.finish) begin
      found_q  <= (func_q == bssl_pkg::FUNC_QUERY) && hit;
      status_q <= status_next;
    end
  end

  assign found       = found_q;
  assign status      = status_q;
  assign entry_count = bssl_pkg::ENTRY_W'(count);

endmodule

FILE: sv/bssl_checker.sv
// port-level checks for the lookup unit and their bind
module bssl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            found,
  input logic [bssl_pkg::STATUS_W-1:0]   status,
  input logic [bssl_pkg::ENTRY_W-1:0]    entry_count
);

  // a result only appears once the unit has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted item keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not occupy the unit");

  // a hit never carries an error status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == bssl_pkg::STATUS_OK))
    else $error("found with error status");

  // the stored count only moves together with a result
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (!done && !$past(rst)) |-> $stable(entry_count))
    else $error("entry count changed without a result");

  // reset empties the table and drops the strobe
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (entry_count == '0 && !done))
    else $error("reset did not clear the table");

endmodule

bind bucketed_sorted_set_lookup_unit bssl_checker u_bssl_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .found       (found),
  .status      (status),
  .entry_count (entry_count)
);

FILE: tb/bucketed_sorted_set_lookup_unit_test.sv
// self-checking testbench for the bucketed sorted-set lookup unit
module bucketed_sorted_set_lookup_unit_test;

  localparam int KEY_W = bssl_pkg::KEY_W;
  localparam int FUNC_W = bssl_pkg::FUNC_W;
  localparam int STATUS_W = bssl_pkg::STATUS_W;
  localparam int ENTRY_W = bssl_pkg::ENTRY_W;
  localparam int DEPTH = bssl_pkg::TABLE_DEPTH_DEF;
  localparam int BKT_BITS = bssl_pkg::BKT_SEL_W_DEF;
  localparam int NUM_BKTS = 1 << BKT_BITS;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT = 10000;
  localparam int TAIL_CYCLES = 64;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } lookup_item_t;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_count;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [FUNC_W-1:0]   func = '0;
  logic [KEY_W-1:0]    key = '0;
  logic                busy;
  logic                done;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  entry_count;

  bucketed_sorted_set_lookup_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .key(key),
    .done(done),
    .found(found),
    .status(status),
    .entry_count(entry_count)
  );

  // shadow copy of the key table and bucket index
  logic [KEY_W-1:0]   key_table [0:DEPTH-1];
  logic [ENTRY_W-1:0] bucket_start [0:NUM_BKTS];
  int unsigned        stored = 0;
  int unsigned        last_bucket = 0;
  logic [KEY_W-1:0]   prev_key = '0;

  lookup_item_t   queued_items[$];
  lookup_result_t pending_results[$];
  int             mismatches = 0;
  int             sender_idle_pct = 0;
  int             random_sent = 0;
  int             stall_cycles = 0;
  bit             item_taken = 1'b0;

  function automatic int unsigned bucket_index(logic [KEY_W-1:0] k);
    return int'(k >> (KEY_W - BKT_BITS));
  endfunction

  // first table slot of a bucket; unfilled buckets start at the current count
  function automatic int unsigned bucket_base(int unsigned b);
    if (b == 0) return 0;
    if (b <= last_bucket) return bucket_start[b];
    return stored;
  endfunction

  // binary search within the key's bucket
  function automatic logic holds_key(logic [KEY_W-1:0] k);
    int unsigned b;
    int unsigned lo;
    int unsigned hi;
    int unsigned stop;
    int unsigned mid;
    b = bucket_index(k);
    lo = bucket_base(b);
    stop = bucket_base(b + 1);
    if (stop > stored) stop = stored;
    hi = stop;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_table[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return (lo < stop) && (key_table[lo] == k);
  endfunction

  // append in order, filling the start of every bucket passed
  function automatic logic [STATUS_W-1:0] store_key(logic [KEY_W-1:0] k);
    int unsigned b;
    if (stored >= DEPTH) return bssl_pkg::STATUS_FULL;
    if (k < prev_key) return bssl_pkg::STATUS_ORDER;
    key_table[stored] = k;
    b = bucket_index(k);
    while (last_bucket < b) begin
      last_bucket++;
      bucket_start[last_bucket] = ENTRY_W'(stored);
    end
    stored++;
    prev_key = k;
    return bssl_pkg::STATUS_OK;
  endfunction

  function automatic lookup_result_t apply_item(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
    lookup_result_t r;
    r = '0;
    case (f)
      bssl_pkg::FUNC_APPEND: r.status = store_key(k);
      bssl_pkg::FUNC_QUERY: r.found = holds_key(k);
      bssl_pkg::FUNC_CLEAR: begin
        stored = 0;
        last_bucket = 0;
        prev_key = '0;
      end
      default: ;
    endcase
    r.entry_count = ENTRY_W'(stored);
    return r;
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_item(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
    lookup_item_t it;
    it.func = f;
    it.key = k;
    queued_items.push_back(it);
  endfunction

  // next key in order; saturates at the top of the key space
  function automatic logic [KEY_W-1:0] next_key(logic [KEY_W-1:0] from, int style);
    logic [KEY_W-1:0] delta;
    logic [KEY_W-1:0] sum;
    case (style)
      0: delta = rand_key() >> $urandom_range(16, 4);
      1: delta = rand_key() >> $urandom_range(63, 44);
      2: delta = KEY_W'($urandom_range(1, 0));
      default: delta = rand_key() >> $urandom_range(3, 1);
    endcase
    sum = from + delta;
    return (sum < from) ? KEY_MAX : sum;
  endfunction

  // lookup key: mostly stored keys and their neighbors
  function automatic logic [KEY_W-1:0] query_key();
    logic [KEY_W-1:0] held;
    logic [KEY_W-1:0] r;
    held = (stored != 0) ? key_table[$urandom_range(stored - 1, 0)] : rand_key();
    r = rand_key();
    case ($urandom_range(7, 0))
      0: return r;
      4: return held + 1'b1;
      5: return held - 1'b1;
      6: return {r[KEY_W-1 -: BKT_BITS], held[KEY_W-BKT_BITS-1:0]};
      7: case ($urandom_range(2, 0))
        0: return '0;
        1: return KEY_MAX;
        default: return prev_key;
      endcase
      default: return held;
    endcase
  endfunction

  // wait until every queued item has been taken
  task automatic drain_items();
    do @(posedge clk); while (queued_items.size() != 0 || start);
  endtask

  // an optional clear, then ordered appends mixed with lookups and a few out-of-order keys
  task automatic build_run();
    logic [KEY_W-1:0] last_key;
    int n;
    int style;
    int r;
    if ($urandom_range(99, 0) < 30 || stored > 3000 ||
        prev_key[KEY_W-1 -: 2] == 2'b11) begin
      queue_item(bssl_pkg::FUNC_CLEAR, rand_key());
      random_sent++;
      last_key = '0;
    end else begin
      last_key = prev_key;
    end
    n = $urandom_range(60, 1);
    style = $urandom_range(3, 0);
    repeat (n) begin
      r = $urandom_range(99, 0);
      if (r < 25) begin
        queue_item(bssl_pkg::FUNC_QUERY, query_key());
      end else if (r < 33 && last_key != 0) begin
        queue_item(bssl_pkg::FUNC_APPEND, rand_key() % last_key);
      end else begin
        last_key = next_key(last_key, style);
        queue_item(bssl_pkg::FUNC_APPEND, last_key);
      end
      random_sent++;
    end
  endtask

  task automatic probe_run();
    repeat ($urandom_range(40, 1)) begin
      queue_item(bssl_pkg::FUNC_QUERY, query_key());
      random_sent++;
    end
  endtask

  // unused codes, stray clears, out-of-order appends, random lookups
  task automatic noise_run();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(3, 0))
        0: queue_item(FUNC_UNUSED, rand_key());
        1: queue_item(bssl_pkg::FUNC_CLEAR, rand_key());
        2: queue_item(bssl_pkg::FUNC_APPEND,
                      (prev_key != 0) ? rand_key() % prev_key : rand_key());
        default: queue_item(bssl_pkg::FUNC_QUERY, rand_key());
      endcase
      random_sent++;
    end
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // driver: present the head of the queue, idling at random between items
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (queued_items.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        start <= 1'b1;
        func <= queued_items[0].func;
        key <= queued_items[0].key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check each result against the oldest expectation, predict taken items
  always @(posedge clk) begin
    lookup_result_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual found %0d status %0d count %0d",
                   $time, found, status, entry_count);
        end else begin
          want = pending_results.pop_front();
          check_field("found", want.found, found);
          check_field("status", want.status, status);
          check_field("entry_count", want.entry_count, entry_count);
        end
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        pending_results.push_back(apply_item(func, key));
        void'(queued_items.pop_front());
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("bucketed_sorted_set_lookup_unit_test: FAIL");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 34;

    // directed: empty table, duplicates, bucket fills, ordering, unused code, clear
    queue_item(bssl_pkg::FUNC_QUERY, '0);
    queue_item(bssl_pkg::FUNC_APPEND, '0);
    queue_item(bssl_pkg::FUNC_APPEND, '0);
    queue_item(bssl_pkg::FUNC_APPEND, 64'd1);
    queue_item(bssl_pkg::FUNC_APPEND, 64'd5 << 54);
    queue_item(bssl_pkg::FUNC_APPEND, 64'd3);
    queue_item(bssl_pkg::FUNC_APPEND, (64'd5 << 54) + 64'd7);
    queue_item(bssl_pkg::FUNC_APPEND, KEY_MAX);
    queue_item(bssl_pkg::FUNC_QUERY, '0);
    queue_item(bssl_pkg::FUNC_QUERY, 64'd1);
    queue_item(bssl_pkg::FUNC_QUERY, 64'd2);
    queue_item(bssl_pkg::FUNC_QUERY, 64'd5 << 54);
    queue_item(bssl_pkg::FUNC_QUERY, (64'd5 << 54) + 64'd1);
    queue_item(bssl_pkg::FUNC_QUERY, (64'd5 << 54) + 64'd7);
    queue_item(bssl_pkg::FUNC_QUERY, 64'd500 << 54);
    queue_item(bssl_pkg::FUNC_QUERY, KEY_MAX);
    queue_item(bssl_pkg::FUNC_QUERY, KEY_MAX - 1'b1);
    queue_item(FUNC_UNUSED, KEY_MAX);
    queue_item(bssl_pkg::FUNC_CLEAR, rand_key());
    queue_item(bssl_pkg::FUNC_QUERY, '0);
    queue_item(bssl_pkg::FUNC_QUERY, KEY_MAX);
    queue_item(bssl_pkg::FUNC_APPEND, KEY_MAX);
    queue_item(bssl_pkg::FUNC_QUERY, KEY_MAX);
    queue_item(bssl_pkg::FUNC_APPEND, '0);
    queue_item(FUNC_UNUSED, '0);
    drain_items();

    // random runs; sender idling goes from 34 to 64 percent, then off for the last third
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) sender_idle_pct = 34;
      else if (random_sent < 2 * RANDOM_ITEMS / 3) sender_idle_pct = 64;
      else sender_idle_pct = 0;
      pick = $urandom_range(99, 0);
      if (pick < 50) build_run();
      else if (pick < 85) probe_run();
      else noise_run();
      drain_items();
    end

    // let the last results come out, then allow for stray ones
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("bucketed_sorted_set_lookup_unit_test: PASS");
    end else begin
      $display("bucketed_sorted_set_lookup_unit_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bssl_pkg.sv
sv/bssl_ctrl.sv
sv/bssl_dp.sv
sv/bucketed_sorted_set_lookup_unit.sv
sv/bssl_checker.sv
tb/bucketed_sorted_set_lookup_unit_test.sv
